>>> sv/ellipse_bresenham_raster_core_assert.svh
// ----------------------------------------------------------------------------
// ellipse_bresenham_raster_core_assert.svh
// assertion macros used by the checker file of the ellipse rasteriser
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_BRESENHAM_RASTER_CORE_ASSERT_SVH
`define ELLIPSE_BRESENHAM_RASTER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define EBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define EBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ebr_pkg.sv
// ----------------------------------------------------------------------------
// ebr_pkg
// widths, codes and controller/datapath interface types of the ellipse
// rasteriser
// ----------------------------------------------------------------------------
package ebr_pkg;

	// coordinate and field widths
	localparam int CoordBits  = 12;
	localparam int AxisBits   = CoordBits - 1;
	localparam int OffYBits   = CoordBits + 1;
	localparam int OutBits    = CoordBits + 2;
	localparam int SqBits     = 2 * AxisBits;
	localparam int ProdBits   = SqBits + CoordBits;
	localparam int ErrBits    = 3 * CoordBits + 4;
	localparam int CalcBits   = ErrBits + 4;

	// stream packing
	localparam int InFieldBits = 2 * CoordBits + 2 * AxisBits;
	localparam int InDataBits  = ((InFieldBits + 7) / 8) * 8;
	localparam int OutDataBits = ((4 * OutBits + 7) / 8) * 8;

	// operation codes carried on s_tuser
	localparam logic OpStart = 1'b0;
	localparam logic OpStep  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic start_load;
		logic init_mul;
		logic init_fin;
		logic step_mul;
		logic step_upd;
	} ebr_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
	} ebr_stat_t;

endpackage

>>> sv/ebr_ctrl.sv
// ----------------------------------------------------------------------------
// ebr_ctrl
// sequencer of the ellipse rasteriser: takes one transaction at a time and
// steps the datapath through set-up or one point update
// ----------------------------------------------------------------------------
module ebr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_tuser,
	input  ebr_pkg::ebr_stat_t stat,
	output ebr_pkg::ebr_cmd_t  cmd
);
	import ebr_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INIT  = 2'd1;
	localparam logic [1:0] ST_EINIT = 2'd2;
	localparam logic [1:0] ST_STEP  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OpStart) begin
						cmd.start_load = 1'b1;
						state_d        = ST_INIT;
					end else begin
						cmd.step_mul = 1'b1;
						state_d      = ST_STEP;
					end
				end
			end
			ST_INIT: begin
				cmd.init_mul = 1'b1;
				state_d      = ST_EINIT;
			end
			ST_EINIT: begin
				if (stat.out_free) begin
					cmd.init_fin = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_STEP: begin
				if (stat.out_free) begin
					cmd.step_upd = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/ebr_dp.sv
// ----------------------------------------------------------------------------
// ebr_dp
// datapath of the ellipse rasteriser: two shared multipliers, the walk state,
// the move decision with error update, and the output register
// ----------------------------------------------------------------------------
module ebr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ebr_pkg::ebr_cmd_t               cmd,
	output ebr_pkg::ebr_stat_t              stat,
	input  logic [ebr_pkg::InDataBits-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ebr_pkg::OutDataBits-1:0] m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import ebr_pkg::*;

	// input fields
	logic [CoordBits-1:0] in_cx;
	logic [CoordBits-1:0] in_cy;
	logic [AxisBits-1:0]  in_a;
	logic [AxisBits-1:0]  in_b;

	// walk state
	logic                       active_q;
	logic [CoordBits-1:0]       x_q;
	logic signed [OffYBits-1:0] y_q;
	logic signed [ErrBits-1:0]  e_q;
	logic [SqBits-1:0]          a2_q;
	logic [SqBits-1:0]          b2_q;
	logic [CoordBits-1:0]       cx_q;
	logic [CoordBits-1:0]       cy_q;
	logic [AxisBits-1:0]        b_q;
	logic [ProdBits-1:0]        p_q;
	logic [ProdBits-1:0]        q_q;

	// multipliers
	logic [SqBits-1:0]    m0a;
	logic [CoordBits-1:0] m0b;
	logic [SqBits-1:0]    m1a;
	logic [CoordBits-1:0] m1b;
	logic [ProdBits-1:0]  mul0;
	logic [ProdBits-1:0]  mul1;

	// error arithmetic
	logic signed [CalcBits-1:0] e_w;
	logic signed [CalcBits-1:0] e2;
	logic signed [CalcBits-1:0] p2;
	logic signed [CalcBits-1:0] q2;
	logic signed [CalcBits-1:0] a2w;
	logic signed [CalcBits-1:0] b2w;
	logic signed [CalcBits-1:0] d1;
	logic signed [CalcBits-1:0] d2;
	logic signed [CalcBits-1:0] h_term;
	logic signed [CalcBits-1:0] v_term;
	logic signed [CalcBits-1:0] e_next;
	logic signed [CalcBits-1:0] e_init;
	logic                       go_x;
	logic                       go_y;
	logic [CoordBits-1:0]       x_next;
	logic signed [OffYBits-1:0] y_next;
	logic                       last;

	// pixel coordinates
	logic [OutBits-1:0]     px_right;
	logic [OutBits-1:0]     px_left;
	logic [OutBits-1:0]     py_down;
	logic [OutBits-1:0]     py_up;
	logic [OutDataBits-1:0] pix_data;

	// output register
	logic                   m_tvalid_q;
	logic [OutDataBits-1:0] m_tdata_q;
	logic                   m_tuser_q;
	logic                   m_tlast_q;

	assign in_cx = s_tdata[CoordBits-1:0];
	assign in_cy = s_tdata[2*CoordBits-1:CoordBits];
	assign in_a  = s_tdata[2*CoordBits+AxisBits-1:2*CoordBits];
	assign in_b  = s_tdata[2*CoordBits+2*AxisBits-1:2*CoordBits+AxisBits];

	// operand selection: squares on start, a2*b at set-up, b2*x and a2*y on step
	always_comb begin
		m0a = b2_q;
		m0b = x_q;
		m1a = a2_q;
		m1b = y_q[CoordBits-1:0];
		if (cmd.start_load) begin
			m0a = SqBits'(in_a);
			m0b = CoordBits'(in_a);
			m1a = SqBits'(in_b);
			m1b = CoordBits'(in_b);
		end else if (cmd.init_mul) begin
			m1b = CoordBits'(b_q);
		end
	end

	assign mul0 = ProdBits'(m0a) * ProdBits'(m0b);
	assign mul1 = ProdBits'(m1a) * ProdBits'(m1b);

	// widened terms
	assign e_w = CalcBits'(e_q);
	assign e2  = {e_w[CalcBits-2:0], 1'b0};
	assign p2  = signed'({{(CalcBits-ProdBits-1){1'b0}}, p_q, 1'b0});
	assign q2  = signed'({{(CalcBits-ProdBits-1){1'b0}}, q_q, 1'b0});
	assign a2w = signed'({{(CalcBits-SqBits){1'b0}}, a2_q});
	assign b2w = signed'({{(CalcBits-SqBits){1'b0}}, b2_q});

	// decision terms, with the products of the current point
	assign d1 = e2 + q2 - CalcBits'(1);
	assign d2 = e2 - p2 - CalcBits'(1);

	// move choice: horizontal moves x, vertical moves y, diagonal both
	always_comb begin
		if (e_w < 0) begin
			go_x = 1'b1;
			go_y = !(d1 < 0);
		end else if (e_w == 0) begin
			go_x = 1'b1;
			go_y = 1'b1;
		end else begin
			go_x = (d2 <= 0);
			go_y = 1'b1;
		end
	end

	// error increments folded to the products of the current point
	assign h_term = p2 + b2w + (b2w <<< 1);
	assign v_term = a2w + (a2w <<< 1) - q2;
	assign e_next = e_w + (go_x ? h_term : CalcBits'(0)) + (go_y ? v_term : CalcBits'(0));
	assign e_init = a2w + b2w - q2;

	assign x_next = x_q + CoordBits'(go_x);
	assign y_next = y_q - OffYBits'(go_y);
	assign last   = y_next[OffYBits-1];

	// mirrored pixels of the current point
	assign px_right = OutBits'(cx_q) + OutBits'(x_q);
	assign px_left  = OutBits'(cx_q) - OutBits'(x_q);
	assign py_down  = OutBits'(cy_q) + OutBits'(y_q[CoordBits-1:0]);
	assign py_up    = OutBits'(cy_q) - OutBits'(y_q[CoordBits-1:0]);

	always_comb begin
		pix_data = '0;
		pix_data[OutBits-1:0]           = px_right;
		pix_data[2*OutBits-1:OutBits]   = px_left;
		pix_data[3*OutBits-1:2*OutBits] = py_down;
		pix_data[4*OutBits-1:3*OutBits] = py_up;
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			a2_q <= mul0[SqBits-1:0];
			b2_q <= mul1[SqBits-1:0];
			cx_q <= in_cx;
			cy_q <= in_cy;
			b_q  <= in_b;
		end
		if (cmd.init_mul) begin
			q_q <= mul1;
		end
		if (cmd.step_mul) begin
			p_q <= mul0;
			q_q <= mul1;
		end
		if (cmd.init_fin) begin
			x_q <= '0;
			y_q <= OffYBits'(b_q);
			e_q <= e_init[ErrBits-1:0];
		end
		if (cmd.step_upd && active_q) begin
			x_q <= x_next;
			y_q <= y_next;
			e_q <= e_next[ErrBits-1:0];
		end
	end

	// figure in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd.init_fin) begin
			active_q <= 1'b1;
		end else if (cmd.step_upd && active_q && last) begin
			active_q <= 1'b0;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.init_fin || cmd.step_upd) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload, zero when no point is carried
	always_ff @(posedge clk) begin
		if (cmd.step_upd && active_q) begin
			m_tdata_q <= pix_data;
			m_tuser_q <= 1'b1;
			m_tlast_q <= last;
		end else if (cmd.init_fin || cmd.step_upd) begin
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
			m_tlast_q <= 1'b0;
		end
	end

	assign stat.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;
	assign m_tuser       = m_tuser_q;
	assign m_tlast       = m_tlast_q;

endmodule

>>> sv/ellipse_bresenham_raster_core.sv
// ----------------------------------------------------------------------------
// ellipse_bresenham_raster_core
// Bresenham ellipse rasteriser, one quadrant walked and mirrored four ways
// ----------------------------------------------------------------------------
// Usage:
// - s_* carries commands: s_tuser 0 starts a figure from the centre and
//   semi-axes in s_tdata, s_tuser 1 asks for the next point set.
// - m_* returns exactly one transaction per command. m_tuser marks a
//   transaction that carries four pixels; m_tlast marks the final point set.
// - Start and steps taken with no figure in progress return all zeros.
// - A step multiplies (b2*x and a2*y), then makes the move decision and
//   error update; the result is registered with the update.
// - A start computes the squares, then a2*b, then the initial error.
// - s_tready is high only between commands; the next command is taken the
//   cycle after the result is registered, so a new command is not taken
//   while one is still in work.
// - When the receiver stalls, the output register holds its transaction and
//   the final cycle of the next command waits until that register frees.
// - Reset clears the output valid and drops any figure in progress.
// ----------------------------------------------------------------------------
module ellipse_bresenham_raster_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// centre_x, centre_y, axis_a, axis_b, zero pad (low bit first)
	input  logic [ebr_pkg::InDataBits-1:0]  s_tdata,
	// op
	input  logic                            s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// px_right, px_left, py_down, py_up (low bit first)
	output logic [ebr_pkg::OutDataBits-1:0] m_tdata,
	// point_valid
	output logic                            m_tuser,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready
);
	import ebr_pkg::*;

	ebr_cmd_t  cmd;
	ebr_stat_t stat;

	// sequencer
	ebr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic and output register
	ebr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> sv/ebr_chk.sv
// ----------------------------------------------------------------------------
// ebr_chk
// port-level checks of the ellipse rasteriser, bound to the top level
// ----------------------------------------------------------------------------
`include "ellipse_bresenham_raster_core_assert.svh"

module ebr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic [ebr_pkg::InDataBits-1:0]  s_tdata,
	input logic                            s_tuser,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ebr_pkg::OutDataBits-1:0] m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready
);

	// one command at a time
	`EBR_ASSERT_NEXT(a_one_cmd, clk, arst_n, s_tvalid && s_tready, !s_tready, "command taken while busy")

	// a result appears only while a command is in work
	`EBR_ASSERT_NOW(a_rise_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result without a command")

	// a transaction with no point carries zeros and no end mark
	`EBR_ASSERT_NOW(a_empty_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0 && !m_tlast, "empty result not zero")

	// a stalled result holds
	`EBR_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind ellipse_bresenham_raster_core ebr_chk u_chk (.*);
